/* design/shb_pkg.sv */
// shared types and constants for the spatial hash broad-phase block
// no dependencies
package shb_pkg;

    localparam int NUM_BUCKETS  = 512;
    localparam int BKT_W        = $clog2(NUM_BUCKETS);
    localparam int BUCKET_DEPTH = 8;
    localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
    localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int ENT_W        = 6;
    localparam int SLOT_AW      = BKT_W + SLOT_W;
    localparam int CELL_SHIFT   = 5;
    localparam int MAP_OFFSET   = 1650;
    localparam int POS_W        = 14;
    localparam int CELL_W       = POS_W - CELL_SHIFT;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ENT_W-1:0]  entity;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [7:0]        half_w;
        logic [7:0]        half_h;
    } cmd_t;

    typedef struct packed {
        logic [ENT_W-1:0] found_id;
        logic             hit;
        logic             overflow;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic               fill_we;
        logic [BKT_W-1:0]   fill_waddr;
        logic [FILL_W-1:0]  fill_wdata;
        logic               fill_re;
        logic [BKT_W-1:0]   fill_raddr;
        logic               slot_we;
        logic [SLOT_AW-1:0] slot_waddr;
        logic [ENT_W-1:0]   slot_wdata;
        logic               slot_re;
        logic [SLOT_AW-1:0] slot_raddr;
    } mem_req_t;

endpackage

/* design/shb_ram.sv */
// generic simple dual-port ram with registered read data
// no dependencies
module shb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/shb_ctrl.sv */
// command sequencer: cell walk, bucket read-modify-write, query dedup and result register
// depends on shb_pkg
module shb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  shb_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output shb_pkg::rsp_t                 rsp,
    output shb_pkg::mem_req_t             mem_req,
    input  logic [shb_pkg::FILL_W-1:0]    fill_rdata,
    input  logic [shb_pkg::ENT_W-1:0]     slot_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_FILL,
        S_SLOT,
        S_FINISH
    } state_t;

    localparam int PW = shb_pkg::POS_W;
    localparam int CW = shb_pkg::CELL_W;
    localparam logic [shb_pkg::FILL_W-1:0] FILL_W_DEPTH =
        shb_pkg::FILL_W'(shb_pkg::BUCKET_DEPTH);

    state_t                        state_reg;
    logic [shb_pkg::BKT_W-1:0]     clr_addr_reg;
    logic                          clr_rsp_reg;
    logic [1:0]                    op_reg;
    logic [shb_pkg::ENT_W-1:0]     ent_reg;
    logic signed [CW-1:0]          sx_reg, ex_reg, ey_reg, x_reg, y_reg;
    logic [shb_pkg::BKT_W-1:0]     bkt_reg;
    logic [shb_pkg::FILL_W-1:0]    slot_idx_reg;
    logic [shb_pkg::FILL_W-1:0]    fill_cnt_reg;
    logic                          ovf_reg;
    logic [(1 << shb_pkg::ENT_W)-1:0] seen_reg;
    logic                          pend_valid_reg;
    logic [shb_pkg::ENT_W-1:0]     pend_id_reg;
    logic                          rsp_valid_reg;
    shb_pkg::rsp_t                 rsp_reg;

    // rectangle bounds in offset map units, before the cell shift; insert uses half_w on both axes
    logic signed [PW-1:0] px, py, lo_x, hi_x, lo_y, hi_y;
    logic [7:0]           ext_y;
    always_comb
    begin
        ext_y = (cmd.command == shb_pkg::CMD_QUERY) ? cmd.half_h : cmd.half_w;
        px    = PW'(cmd.pos_x) + PW'(shb_pkg::MAP_OFFSET);
        py    = PW'(cmd.pos_y) + PW'(shb_pkg::MAP_OFFSET);
        lo_x  = px - PW'(cmd.half_w);
        hi_x  = px + PW'(cmd.half_w);
        lo_y  = py - PW'(ext_y);
        hi_y  = py + PW'(ext_y);
    end

    // bucket of the current cell
    logic signed [CW:0] bsum;
    logic               bkt_ok;
    logic               last_cell;
    always_comb
    begin
        bsum      = (CW+1)'(x_reg) + (CW+1)'(y_reg);
        bkt_ok    = !bsum[CW] && (int'(bsum) < shb_pkg::NUM_BUCKETS);
        last_cell = (x_reg == ex_reg) && (y_reg == ey_reg);
    end

    logic can_emit;
    logic seen_hit;
    logic slot_more;
    assign can_emit  = !rsp_valid_reg || rsp_ready;
    assign seen_hit  = seen_reg[slot_rdata];
    assign slot_more = (slot_idx_reg + 1'b1) < fill_cnt_reg;

    // result register load
    logic rsp_load;
    always_comb
    begin
        case (state_reg)
            S_SLOT:
            begin
                rsp_load = !seen_hit && pend_valid_reg && can_emit;
            end
            S_FINISH:
            begin
                rsp_load = can_emit;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    // memory requests
    always_comb
    begin
        mem_req            = '0;
        mem_req.slot_wdata = ent_reg;
        mem_req.slot_waddr = {bkt_reg, fill_rdata[shb_pkg::SLOT_W-1:0]};
        mem_req.fill_raddr = bsum[shb_pkg::BKT_W-1:0];
        mem_req.fill_waddr = bkt_reg;
        mem_req.fill_wdata = fill_rdata + 1'b1;
        mem_req.slot_raddr = {bkt_reg, slot_idx_reg[shb_pkg::SLOT_W-1:0]};
        case (state_reg)
            S_CLEAR:
            begin
                mem_req.fill_we    = 1'b1;
                mem_req.fill_waddr = clr_addr_reg;
                mem_req.fill_wdata = '0;
            end
            S_CELL:
            begin
                mem_req.fill_re = bkt_ok;
            end
            S_FILL:
            begin
                if (op_reg == shb_pkg::CMD_INSERT)
                begin
                    mem_req.fill_we = fill_rdata < FILL_W_DEPTH;
                    mem_req.slot_we = fill_rdata < FILL_W_DEPTH;
                end
                else
                begin
                    mem_req.slot_re    = fill_rdata != '0;
                    mem_req.slot_raddr = {bkt_reg, {shb_pkg::SLOT_W{1'b0}}};
                end
            end
            S_SLOT:
            begin
                if (!(!seen_hit && pend_valid_reg && !can_emit) && slot_more)
                begin
                    mem_req.slot_re    = 1'b1;
                    mem_req.slot_raddr = {bkt_reg,
                        slot_idx_reg[shb_pkg::SLOT_W-1:0] + 1'b1};
                end
            end
            default:
            begin
            end
        endcase
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // state, walk registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_rsp_reg    <= 1'b0;
            op_reg         <= '0;
            ovf_reg        <= 1'b0;
            seen_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == shb_pkg::BKT_W'(shb_pkg::NUM_BUCKETS - 1))
                    begin
                        state_reg <= clr_rsp_reg ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        op_reg         <= cmd.command;
                        ent_reg        <= cmd.entity;
                        sx_reg         <= lo_x[PW-1:shb_pkg::CELL_SHIFT];
                        ex_reg         <= hi_x[PW-1:shb_pkg::CELL_SHIFT];
                        ey_reg         <= hi_y[PW-1:shb_pkg::CELL_SHIFT];
                        x_reg          <= lo_x[PW-1:shb_pkg::CELL_SHIFT];
                        y_reg          <= lo_y[PW-1:shb_pkg::CELL_SHIFT];
                        ovf_reg        <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        case (cmd.command)
                            shb_pkg::CMD_INSERT:
                            begin
                                state_reg <= S_CELL;
                            end
                            shb_pkg::CMD_QUERY:
                            begin
                                seen_reg  <= '0;
                                state_reg <= S_CELL;
                            end
                            shb_pkg::CMD_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                clr_rsp_reg  <= 1'b1;
                                state_reg    <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_CELL:
                begin
                    bkt_reg <= bsum[shb_pkg::BKT_W-1:0];
                    if (bkt_ok)
                    begin
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        state_reg <= last_cell ? S_FINISH : S_CELL;
                        x_reg     <= (x_reg == ex_reg) ? sx_reg : x_reg + 1'b1;
                        y_reg     <= (x_reg == ex_reg) ? y_reg + 1'b1 : y_reg;
                    end
                end
                S_FILL:
                begin
                    slot_idx_reg <= '0;
                    fill_cnt_reg <= fill_rdata;
                    if (op_reg == shb_pkg::CMD_QUERY && fill_rdata != '0)
                    begin
                        state_reg <= S_SLOT;
                    end
                    else
                    begin
                        if (op_reg == shb_pkg::CMD_INSERT && fill_rdata >= FILL_W_DEPTH)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        state_reg <= last_cell ? S_FINISH : S_CELL;
                        x_reg     <= (x_reg == ex_reg) ? sx_reg : x_reg + 1'b1;
                        y_reg     <= (x_reg == ex_reg) ? y_reg + 1'b1 : y_reg;
                    end
                end
                S_SLOT:
                begin
                    if (!(!seen_hit && pend_valid_reg && !can_emit))
                    begin
                        // new id: previous pending hit goes out, this one waits
                        if (!seen_hit)
                        begin
                            seen_reg[slot_rdata] <= 1'b1;
                            pend_valid_reg       <= 1'b1;
                            pend_id_reg          <= slot_rdata;
                            if (pend_valid_reg)
                            begin
                                rsp_reg.found_id <= pend_id_reg;
                                rsp_reg.hit      <= 1'b1;
                                rsp_reg.overflow <= 1'b0;
                                rsp_reg.last     <= 1'b0;
                            end
                        end
                        if (slot_more)
                        begin
                            slot_idx_reg <= slot_idx_reg + 1'b1;
                        end
                        else
                        begin
                            state_reg <= last_cell ? S_FINISH : S_CELL;
                            x_reg     <= (x_reg == ex_reg) ? sx_reg : x_reg + 1'b1;
                            y_reg     <= (x_reg == ex_reg) ? y_reg + 1'b1 : y_reg;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (can_emit)
                    begin
                        rsp_reg.found_id <= pend_valid_reg ? pend_id_reg : '0;
                        rsp_reg.hit      <= pend_valid_reg;
                        rsp_reg.overflow <= (op_reg == shb_pkg::CMD_INSERT) && ovf_reg;
                        rsp_reg.last     <= 1'b1;
                        pend_valid_reg   <= 1'b0;
                        clr_rsp_reg      <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/spatial_hash_broadphase.sv */
// insert walks every covered cell and writes each in-range bucket with room; query walks
// every covered cell and reads each stored entry of each in-range bucket; clear zeroes every
// bucket count; all bounded by the single read port of the fill and slot memories, plus result stalls.
// one command in flight at a time; the next is taken once the final result is registered.
// reset: a pass over every bucket zeroes the bucket fill memory, no command is taken meanwhile.
// top level of the spatial hash broad-phase block
// depends on shb_pkg, shb_ram, shb_ctrl
module spatial_hash_broadphase (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  shb_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output shb_pkg::rsp_t rsp
);

    shb_pkg::mem_req_t               mem_req;
    logic [shb_pkg::FILL_W-1:0]      fill_rdata;
    logic [shb_pkg::ENT_W-1:0]       slot_rdata;

    // per-bucket entry count
    shb_ram #(
        .WIDTH(shb_pkg::FILL_W),
        .DEPTH(shb_pkg::NUM_BUCKETS)
    ) u_fill_ram (
        .clk  (clk),
        .we   (mem_req.fill_we),
        .waddr(mem_req.fill_waddr),
        .wdata(mem_req.fill_wdata),
        .re   (mem_req.fill_re),
        .raddr(mem_req.fill_raddr),
        .rdata(fill_rdata)
    );

    // bucket slots holding entity ids
    shb_ram #(
        .WIDTH(shb_pkg::ENT_W),
        .DEPTH(shb_pkg::NUM_BUCKETS * shb_pkg::BUCKET_DEPTH)
    ) u_slot_ram (
        .clk  (clk),
        .we   (mem_req.slot_we),
        .waddr(mem_req.slot_waddr),
        .wdata(mem_req.slot_wdata),
        .re   (mem_req.slot_re),
        .raddr(mem_req.slot_raddr),
        .rdata(slot_rdata)
    );

    // sequencer
    shb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .fill_rdata(fill_rdata),
        .slot_rdata(slot_rdata)
    );

    // checks
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second transaction taken while busy");

    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.last && rsp.found_id == '0)
        else $error("non-hit result not final or carries an id");

    a_hit_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit |-> !rsp.overflow)
        else $error("query hit flagged overflow");

    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> !(rsp_valid && !rsp.last))
        else $error("command taken before final result");

endmodule

/* dv/spatial_hash_broadphase_test.sv */
// testbench for the spatial hash broad-phase block: directed and random commands
// with an internal bucket predictor and an in-order result scoreboard
// depends on shb_pkg and spatial_hash_broadphase
module spatial_hash_broadphase_test;

    localparam int MAX_ENT     = 64;
    localparam int WDOG_LIMIT  = 20000;
    localparam int N_RANDOM    = 305;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 40;
    localparam logic [1:0] CMD_NOP = 2'd3;

    // bucket predictor and expected result store
    class hash_scoreboard;
        int unsigned fill [shb_pkg::NUM_BUCKETS];
        logic [shb_pkg::ENT_W-1:0] slots [shb_pkg::NUM_BUCKETS][shb_pkg::BUCKET_DEPTH];
        shb_pkg::rsp_t pending [$];
        int errors;

        function new();
            foreach (fill[i]) fill[i] = 0;
            errors = 0;
        endfunction

        function int cell_of(int v);
            return v >>> shb_pkg::CELL_SHIFT;
        endfunction

        function void push_rsp(logic [shb_pkg::ENT_W-1:0] id, logic h, logic ov, logic l);
            shb_pkg::rsp_t r;
            r.found_id = id;
            r.hit = h;
            r.overflow = ov;
            r.last = l;
            pending = {pending, r};
        endfunction

        // note an accepted command and predict its results
        function void note_cmd(shb_pkg::cmd_t c);
            int px, py, hw, hh, sx, ex, sy, ey, b, n;
            logic ovf;
            bit seen [MAX_ENT];
            logic [shb_pkg::ENT_W-1:0] id;
            px = int'(c.pos_x) + shb_pkg::MAP_OFFSET;
            py = int'(c.pos_y) + shb_pkg::MAP_OFFSET;
            hw = int'(c.half_w);
            hh = int'(c.half_h);
            ovf = 1'b0;
            n = 0;
            if (c.command == shb_pkg::CMD_INSERT)
            begin
                sx = cell_of(px - hw); ex = cell_of(px + hw);
                sy = cell_of(py - hw); ey = cell_of(py + hw);
                for (int y = sy; y <= ey; y++)
                    for (int x = sx; x <= ex; x++)
                    begin
                        b = x + y;
                        if (b < 0 || b >= shb_pkg::NUM_BUCKETS) continue;
                        if (fill[b] >= shb_pkg::BUCKET_DEPTH)
                        begin
                            ovf = 1'b1;
                            continue;
                        end
                        slots[b][fill[b]] = c.entity;
                        fill[b]++;
                    end
                push_rsp('0, 1'b0, ovf, 1'b1);
            end
            else if (c.command == shb_pkg::CMD_QUERY)
            begin
                foreach (seen[i]) seen[i] = 0;
                sx = cell_of(px - hw); ex = cell_of(px + hw);
                sy = cell_of(py - hh); ey = cell_of(py + hh);
                for (int y = sy; y <= ey; y++)
                    for (int x = sx; x <= ex; x++)
                    begin
                        b = x + y;
                        if (b < 0 || b >= shb_pkg::NUM_BUCKETS) continue;
                        for (int i = 0; i < fill[b]; i++)
                        begin
                            id = slots[b][i];
                            if (seen[id]) continue;
                            seen[id] = 1;
                            push_rsp(id, 1'b1, 1'b0, 1'b0);
                            n++;
                        end
                    end
                if (n == 0) push_rsp('0, 1'b0, 1'b0, 1'b1);
                else pending[pending.size()-1].last = 1'b1;
            end
            else
            begin
                if (c.command == shb_pkg::CMD_CLEAR)
                    foreach (fill[i]) fill[i] = 0;
                push_rsp('0, 1'b0, 1'b0, 1'b1);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_rsp(shb_pkg::rsp_t got);
            shb_pkg::rsp_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.found_id !== want.found_id)
                $display("%0t found_id mismatch: expected %0d actual %0d",
                         $time, want.found_id, got.found_id);
            if (got.hit !== want.hit)
                $display("%0t hit mismatch: expected %0b actual %0b", $time, want.hit, got.hit);
            if (got.overflow !== want.overflow)
                $display("%0t overflow mismatch: expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
            if (got.last !== want.last)
                $display("%0t last mismatch: expected %0b actual %0b", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_ready;
    shb_pkg::cmd_t cmd;
    logic          rsp_valid;
    logic          rsp_ready;
    shb_pkg::rsp_t rsp;

    hash_scoreboard sb;
    int   idle_cycles;
    int   wait_left;
    int   n_sent;
    logic hold_off;
    bit   stim_done;

    spatial_hash_broadphase DUT (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // send one transaction after a random gap
    task automatic send_cmd(logic [1:0] op, logic [5:0] ent, logic [11:0] x,
                            logic [11:0] y, logic [7:0] w, logic [7:0] h);
        shb_pkg::cmd_t c;
        int gap;
        c.command = op; c.entity = ent; c.pos_x = x; c.pos_y = y;
        c.half_w = w; c.half_h = h;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_cmd(c);
        n_sent++;
    endtask

    // random command, mostly near the populated map region with small sizes
    task automatic send_random();
        logic [1:0] op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) op = shb_pkg::CMD_INSERT;
        else if (r < 92) op = shb_pkg::CMD_QUERY;
        else if (r < 95) op = shb_pkg::CMD_CLEAR;
        else op = CMD_NOP;
        if ($urandom_range(0, 9) == 0)
            send_cmd(op, 6'($urandom), 12'($urandom), 12'($urandom), 8'($urandom),
                     8'($urandom));
        else
            send_cmd(op, 6'($urandom), 12'(int'($urandom_range(0, 3000)) - 1650),
                     12'(int'($urandom_range(0, 3000)) - 1650),
                     8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)));
    endtask

    // stimulus
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        stim_done = 0;
        n_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // extremes, out of range buckets, duplicates, full buckets
        send_cmd(shb_pkg::CMD_QUERY, 6'd0, 12'sd0, 12'sd0, 8'd255, 8'd255);
        send_cmd(shb_pkg::CMD_INSERT, 6'd63, 12'sh800, 12'sh800, 8'd255, 8'd0);
        send_cmd(shb_pkg::CMD_INSERT, 6'd0, 12'sh7ff, 12'sh7ff, 8'd255, 8'd0);
        send_cmd(shb_pkg::CMD_INSERT, 6'd5, -12'sd1650, -12'sd1650, 8'd0, 8'd0);
        send_cmd(shb_pkg::CMD_INSERT, 6'd6, 12'sd100, 12'sd100, 8'd40, 8'd0);
        send_cmd(shb_pkg::CMD_INSERT, 6'd7, 12'sd100, 12'sd100, 8'd40, 8'd0);
        for (int i = 0; i < 9; i++)
            send_cmd(shb_pkg::CMD_INSERT, 6'(10 + i), 12'sd0, 12'sd0, 8'd0, 8'd0);
        send_cmd(shb_pkg::CMD_QUERY, 6'd0, 12'sd0, 12'sd0, 8'd0, 8'd0);
        send_cmd(shb_pkg::CMD_QUERY, 6'd0, 12'sd100, 12'sd100, 8'd255, 8'd255);
        send_cmd(shb_pkg::CMD_QUERY, 6'd0, 12'sh800, 12'sh800, 8'd255, 8'd255);
        send_cmd(shb_pkg::CMD_QUERY, 6'd0, 12'sh7ff, 12'sh7ff, 8'd255, 8'd0);
        send_cmd(CMD_NOP, 6'd63, 12'sh7ff, 12'sh800, 8'd255, 8'd255);
        send_cmd(shb_pkg::CMD_CLEAR, 6'd0, 12'sd0, 12'sd0, 8'd0, 8'd0);
        send_cmd(shb_pkg::CMD_QUERY, 6'd0, 12'sd0, 12'sd0, 8'd255, 8'd255);
        for (int i = 0; i < N_RANDOM; i++)
            send_random();
        cmd_valid <= 1'b0;
        stim_done = 1;
    end

    // one long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        wait (n_sent >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // receiver with a random wait per transaction
    initial
    begin
        rsp_ready = 1'b0;
        wait_left = $urandom_range(0, 5);
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                sb.check_rsp(rsp);
                wait_left = $urandom_range(0, 5);
            end
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("%0t timeout, %0d results outstanding", $time, sb.pending.size());
                $display("== FAIL ==");
                $finish;
            end
            if (stim_done && sb.pending.size() == 0)
            begin
                repeat (600) @(posedge clk);
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("== PASS ==");
                else
                    $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
design/shb_pkg.sv
design/shb_ram.sv
design/shb_ctrl.sv
design/spatial_hash_broadphase.sv
dv/spatial_hash_broadphase_test.sv
